FILE: hw/rtl/codf_pkg.sv
// ----------------------------------------------------------------------------
// codf_pkg
// shared types, constants and helpers of the clock offset delay filter
// ----------------------------------------------------------------------------
package codf_pkg;

    localparam int unsigned TRIP_W     = 16;
    localparam int unsigned TIME_W     = 31;
    localparam int unsigned OFS_W      = 32;
    localparam int unsigned SCNT_W     = 5;
    // count as seen by the divide-by-five helper, enough for the largest store
    localparam int unsigned CNT_EXT_W  = 7;
    // number of entries averaged, at most a fifth of the largest store
    localparam int unsigned NUM_W      = 4;
    // sum of up to fifteen round trips
    localparam int unsigned SUM_W      = 20;
    localparam int unsigned DIV_CNT_W  = 5;

    localparam logic [TRIP_W-1:0] MAX_TRIP_RST = 16'd1000;

    typedef struct packed {
        logic [TIME_W-1:0] server_time_ms;
        logic [TRIP_W-1:0] round_trip_ms;
        logic [TIME_W-1:0] local_time_ms;
    } rdg_t;

    typedef struct packed {
        logic signed [OFS_W-1:0] offset_ms;
        logic                    accepted;
        logic [TRIP_W-1:0]       estimate_ms;
        logic [SCNT_W-1:0]       stored_count;
    } res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_TOP_RD,
        ST_TOP_CMP,
        ST_SHIFT_RD,
        ST_SHIFT,
        ST_PLACE0,
        ST_EST_SEL,
        ST_MIN_RD,
        ST_MIN_WAIT,
        ST_SUM_RD,
        ST_SUM_ACC,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_OFFS,
        ST_OUT
    } state_t;

    // floor(c / 5) by reciprocal, exact for c below 80
    function automatic logic [NUM_W-1:0] div5(input logic [CNT_EXT_W-1:0] c);
        logic [14:0] prod;
        prod = 15'(c) * 15'd205;
        return prod[13:10];
    endfunction

endpackage

FILE: hw/rtl/clock_offset_delay_filter_core.sv
// ----------------------------------------------------------------------------
// clock_offset_delay_filter_core
// clock offset filter driven by the smallest measured round trips
// ----------------------------------------------------------------------------
// usage: one time reading enters on req_* (valid/stall); req_stall is high
// while a reading is being worked on. each reading gives exactly one result
// item on rsp_* (valid/stall), held stable while rsp_stall is high; the next
// reading is taken while an earlier result still waits.
// cfg_* writes the round trip limit; cfg_ready is always high, write only
// while idle.
// a rejected reading goes straight to its result item. an accepted one is
// checked, then inserted in sorted order: placed directly into an empty store,
// walked in from the top of a partly filled one, and into a full store only
// when smaller than its largest entry, which it overwrites; then the minimum
// is read, or the mean of the smallest fifth is summed and divided, and the
// offset is computed before the output.
// the next reading can be taken in the cycle after the result is registered; a
// stalled result holds the following reading in its output state. the insert
// walk over the ram and the bit serial divider set how long a reading is worked on.
// reset clears the count, offset and output valid and sets the limit to
// 1000; the store itself is not cleared, unfilled entries are never used.
// ----------------------------------------------------------------------------
module clock_offset_delay_filter_core #(
    parameter int unsigned KEEP_COUNT = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_stall,
    input  codf_pkg::rdg_t                     req_data,
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output codf_pkg::res_t                     rsp_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [codf_pkg::TRIP_W-1:0]        cfg_data
);

    localparam int unsigned AW   = $clog2(KEEP_COUNT);
    localparam int unsigned CW   = $clog2(KEEP_COUNT + 1);
    localparam int unsigned HALF = KEEP_COUNT / 2;

    codf_pkg::state_t                 state_reg, state_next;
    logic [codf_pkg::TRIP_W-1:0]      max_reg, max_next;
    logic [CW-1:0]                    count_reg, count_next;
    logic signed [codf_pkg::OFS_W-1:0] offset_reg, offset_next;
    logic                             rsp_valid_reg, rsp_valid_next;
    codf_pkg::res_t                   rsp_reg, rsp_next;

    codf_pkg::rdg_t                   rdg_reg, rdg_next;
    logic                             ok_reg, ok_next;
    logic [AW-1:0]                    j_reg, j_next;
    logic [AW-1:0]                    k_reg, k_next;
    logic [codf_pkg::SUM_W-1:0]       sum_reg, sum_next;
    logic [codf_pkg::NUM_W-1:0]       n_reg, n_next;
    logic [codf_pkg::TRIP_W-1:0]      est_reg, est_next;

    logic                             ram_we;
    logic [AW-1:0]                    ram_waddr;
    logic [codf_pkg::TRIP_W-1:0]      ram_wdata;
    logic [AW-1:0]                    ram_raddr;
    logic [codf_pkg::TRIP_W-1:0]      ram_rdata;
    logic                             div_start;
    logic                             div_done;
    logic [codf_pkg::SUM_W-1:0]       div_quo;

    logic                             req_take;
    logic                             rsp_free;
    logic [AW-1:0]                    j_up;
    logic [CW-1:0]                    count_dec;
    logic [CW+codf_pkg::CNT_EXT_W-1:0] cnt_ext;
    logic [codf_pkg::NUM_W-1:0]       n_calc;
    logic [AW+4:0]                    k_inc;
    logic signed [codf_pkg::OFS_W+1:0] diff;
    logic signed [codf_pkg::OFS_W-1:0] diff_sat;

    codf_ram #(
        .WIDTH (codf_pkg::TRIP_W),
        .DEPTH (KEEP_COUNT)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    codf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (n_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign req_take  = req_valid && !req_stall;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign j_up      = j_reg + AW'(1);
    assign count_dec = count_reg - CW'(1);
    assign cnt_ext   = {{codf_pkg::CNT_EXT_W{1'b0}}, count_reg};
    assign n_calc    = codf_pkg::div5(cnt_ext[codf_pkg::CNT_EXT_W-1:0]);
    assign k_inc     = (AW+5)'(k_reg) + (AW+5)'(1);

    always_comb
    begin
        diff = $signed({3'b000, rdg_reg.local_time_ms})
             - $signed({3'b000, rdg_reg.server_time_ms})
             - $signed({18'd0, est_reg});
        if (diff[codf_pkg::OFS_W+1:codf_pkg::OFS_W-1] == 3'b000 ||
            diff[codf_pkg::OFS_W+1:codf_pkg::OFS_W-1] == 3'b111)
        begin
            diff_sat = diff[codf_pkg::OFS_W-1:0];
        end
        else if (diff[codf_pkg::OFS_W+1])
        begin
            diff_sat = {1'b1, {(codf_pkg::OFS_W-1){1'b0}}};
        end
        else
        begin
            diff_sat = {1'b0, {(codf_pkg::OFS_W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= codf_pkg::ST_IDLE;
            max_reg       <= codf_pkg::MAX_TRIP_RST;
            count_reg     <= '0;
            offset_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            max_reg       <= max_next;
            count_reg     <= count_next;
            offset_reg    <= offset_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        rdg_reg <= rdg_next;
        ok_reg  <= ok_next;
        j_reg   <= j_next;
        k_reg   <= k_next;
        sum_reg <= sum_next;
        n_reg   <= n_next;
        est_reg <= est_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            codf_pkg::ST_IDLE:
            begin
                if (req_take)
                begin
                    state_next = codf_pkg::ST_START;
                end
            end
            codf_pkg::ST_START:
            begin
                if (rdg_reg.round_trip_ms > max_reg)
                begin
                    state_next = codf_pkg::ST_OUT;
                end
                else if (count_reg == CW'(KEEP_COUNT))
                begin
                    state_next = codf_pkg::ST_TOP_RD;
                end
                else if (count_reg == '0)
                begin
                    state_next = codf_pkg::ST_PLACE0;
                end
                else
                begin
                    state_next = codf_pkg::ST_SHIFT_RD;
                end
            end
            codf_pkg::ST_TOP_RD:
            begin
                state_next = codf_pkg::ST_TOP_CMP;
            end
            codf_pkg::ST_TOP_CMP:
            begin
                if (rdg_reg.round_trip_ms >= ram_rdata)
                begin
                    state_next = codf_pkg::ST_EST_SEL;
                end
                else
                begin
                    state_next = codf_pkg::ST_SHIFT_RD;
                end
            end
            codf_pkg::ST_SHIFT_RD:
            begin
                state_next = codf_pkg::ST_SHIFT;
            end
            codf_pkg::ST_SHIFT:
            begin
                if (ram_rdata <= rdg_reg.round_trip_ms)
                begin
                    state_next = codf_pkg::ST_EST_SEL;
                end
                else if (j_reg == '0)
                begin
                    state_next = codf_pkg::ST_PLACE0;
                end
            end
            codf_pkg::ST_PLACE0:
            begin
                state_next = codf_pkg::ST_EST_SEL;
            end
            codf_pkg::ST_EST_SEL:
            begin
                if (count_reg < CW'(HALF) || n_calc == '0)
                begin
                    state_next = codf_pkg::ST_MIN_RD;
                end
                else
                begin
                    state_next = codf_pkg::ST_SUM_RD;
                end
            end
            codf_pkg::ST_MIN_RD:
            begin
                state_next = codf_pkg::ST_MIN_WAIT;
            end
            codf_pkg::ST_MIN_WAIT:
            begin
                state_next = codf_pkg::ST_OFFS;
            end
            codf_pkg::ST_SUM_RD:
            begin
                state_next = codf_pkg::ST_SUM_ACC;
            end
            codf_pkg::ST_SUM_ACC:
            begin
                if (k_inc == (AW+5)'(n_reg))
                begin
                    state_next = codf_pkg::ST_DIV_GO;
                end
                else
                begin
                    state_next = codf_pkg::ST_SUM_RD;
                end
            end
            codf_pkg::ST_DIV_GO:
            begin
                state_next = codf_pkg::ST_DIV_WAIT;
            end
            codf_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = codf_pkg::ST_OFFS;
                end
            end
            codf_pkg::ST_OFFS:
            begin
                state_next = codf_pkg::ST_OUT;
            end
            codf_pkg::ST_OUT:
            begin
                if (rsp_free)
                begin
                    state_next = codf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = codf_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        req_stall      = (state_reg != codf_pkg::ST_IDLE);
        ram_we         = 1'b0;
        ram_waddr      = j_up;
        ram_wdata      = rdg_reg.round_trip_ms;
        ram_raddr      = j_reg;
        div_start      = 1'b0;
        max_next       = max_reg;
        count_next     = count_reg;
        offset_next    = offset_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        rdg_next       = rdg_reg;
        ok_next        = ok_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        sum_next       = sum_reg;
        n_next         = n_reg;
        est_next       = est_reg;

        if (cfg_valid && cfg_ready)
        begin
            max_next = cfg_data;
        end

        unique case (state_reg)
            codf_pkg::ST_IDLE:
            begin
                if (req_take)
                begin
                    rdg_next = req_data;
                end
            end
            codf_pkg::ST_START:
            begin
                ok_next  = (rdg_reg.round_trip_ms <= max_reg);
                est_next = '0;
                j_next   = count_dec[AW-1:0];
            end
            codf_pkg::ST_TOP_RD:
            begin
                ram_raddr = AW'(KEEP_COUNT - 1);
            end
            codf_pkg::ST_TOP_CMP:
            begin
                if (rdg_reg.round_trip_ms < ram_rdata)
                begin
                    // largest entry is overwritten by the walk
                    count_next = CW'(KEEP_COUNT - 1);
                    j_next     = AW'(KEEP_COUNT - 2);
                end
            end
            codf_pkg::ST_SHIFT_RD:
            begin
                ram_raddr = j_reg;
            end
            codf_pkg::ST_SHIFT:
            begin
                ram_we    = 1'b1;
                ram_waddr = j_up;
                ram_raddr = j_reg - AW'(1);
                if (ram_rdata <= rdg_reg.round_trip_ms)
                begin
                    ram_wdata  = rdg_reg.round_trip_ms;
                    count_next = count_reg + CW'(1);
                end
                else
                begin
                    ram_wdata = ram_rdata;
                    j_next    = j_reg - AW'(1);
                end
            end
            codf_pkg::ST_PLACE0:
            begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                ram_wdata  = rdg_reg.round_trip_ms;
                count_next = count_reg + CW'(1);
            end
            codf_pkg::ST_EST_SEL:
            begin
                n_next   = n_calc;
                k_next   = '0;
                sum_next = '0;
            end
            codf_pkg::ST_MIN_RD:
            begin
                ram_raddr = '0;
            end
            codf_pkg::ST_MIN_WAIT:
            begin
                est_next = ram_rdata;
            end
            codf_pkg::ST_SUM_RD:
            begin
                ram_raddr = k_reg;
            end
            codf_pkg::ST_SUM_ACC:
            begin
                sum_next = sum_reg + codf_pkg::SUM_W'(ram_rdata);
                k_next   = k_reg + AW'(1);
            end
            codf_pkg::ST_DIV_GO:
            begin
                div_start = 1'b1;
            end
            codf_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    est_next = div_quo[codf_pkg::TRIP_W-1:0];
                end
            end
            codf_pkg::ST_OFFS:
            begin
                offset_next = diff_sat;
            end
            codf_pkg::ST_OUT:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next        = 1'b1;
                    rsp_next.offset_ms    = offset_reg;
                    rsp_next.accepted     = ok_reg;
                    rsp_next.estimate_ms  = est_reg;
                    rsp_next.stored_count = cnt_ext[codf_pkg::SCNT_W-1:0];
                end
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // checks

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(KEEP_COUNT))
        else $error("store count beyond capacity");

    a_rsp_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == codf_pkg::ST_OUT))
        else $error("result item raised outside output state");

    a_reject_est: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && !rsp_reg.accepted |-> rsp_reg.estimate_ms == '0)
        else $error("rejected item carries an estimate");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == codf_pkg::ST_DIV_WAIT)
        else $error("divider finished outside its wait state");

endmodule

FILE: hw/rtl/codf_ram.sv
// ----------------------------------------------------------------------------
// codf_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module codf_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hw/rtl/codf_div.sv
// ----------------------------------------------------------------------------
// codf_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module codf_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [codf_pkg::SUM_W-1:0]  dividend,
    input  logic [codf_pkg::NUM_W-1:0]  divisor,
    output logic                        done,
    output logic [codf_pkg::SUM_W-1:0]  quotient
);

    logic                               busy_reg, busy_next;
    logic                               done_reg, done_next;
    logic [codf_pkg::DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [codf_pkg::SUM_W-1:0]         quo_reg, quo_next;
    logic [codf_pkg::NUM_W-1:0]         rem_reg, rem_next;
    logic [codf_pkg::NUM_W-1:0]         dsr_reg, dsr_next;
    logic [codf_pkg::NUM_W:0]           rem_sh;
    logic [codf_pkg::NUM_W:0]           rem_sub;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    always_comb
    begin
        rem_sh    = {rem_reg, quo_reg[codf_pkg::SUM_W-1]};
        rem_sub   = rem_sh - {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            // dividend bits shift out at the top while quotient bits enter below
            if (rem_sh >= {1'b0, dsr_reg})
            begin
                rem_next = rem_sub[codf_pkg::NUM_W-1:0];
                quo_next = {quo_reg[codf_pkg::SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[codf_pkg::NUM_W-1:0];
                quo_next = {quo_reg[codf_pkg::SUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == codf_pkg::DIV_CNT_W'(codf_pkg::SUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
